@@ rtl/core/xbc_pkg.sv @@
// Shared types, constants and the mixing function for the XTEA cipher pipeline.
`timescale 1ns / 1ps

package xbc_pkg;

  // Word and key geometry.
  localparam int WORD_W    = 32;
  localparam int NUM_KEYS  = 4;
  localparam int KEY_IDX_W = 2;
  localparam int CFG_IDX_W = 8;

  // Round constant of the key schedule.
  localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

  // Command codes.
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Highest configuration index that holds a key word.
  localparam logic [CFG_IDX_W-1:0] LAST_KEY_IDX = 8'd3;

  typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

  // Payload that travels down the pipeline.
  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } pay_t;

  // One pipeline slot: valid bit plus payload.
  typedef struct packed {
    logic valid;
    pay_t pay;
  } blk_t;

  // Feistel mixing term: ((v << 4) ^ (v >> 5)) + v.
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

@@ rtl/core/xbc_half_round.sv @@
// One registered half-round of XTEA, serving both encrypt and decrypt words.
`timescale 1ns / 1ps

module xbc_half_round #(
  parameter int ROUNDS = 32,
  parameter int STAGE  = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  xbc_pkg::key_t key_i,
  input  xbc_pkg::blk_t blk_i,
  output xbc_pkg::blk_t blk_o
);
  import xbc_pkg::*;

  // DELTA additions made to the sum before this half, and the schedule sums at this point.
  localparam int                 H        = (STAGE + 1) / 2;
  localparam logic               EVEN     = ((STAGE % 2) == 0);
  localparam logic [WORD_W-1:0]  ENC_SUM  = 32'(DELTA * H);
  localparam logic [WORD_W-1:0]  DEC_SUM  = 32'(DELTA * (ROUNDS - H));
  localparam logic [KEY_IDX_W-1:0] ENC_KIDX = EVEN ? ENC_SUM[1:0] : ENC_SUM[12:11];
  localparam logic [KEY_IDX_W-1:0] DEC_KIDX = EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

  logic              dec;
  logic              upd_v0;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] tgt;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] key;
  logic [WORD_W-1:0] f;
  logic [WORD_W-1:0] res;
  logic              valid_r;
  pay_t              pay_r;
  pay_t              pay_nxt;

  // Encryption updates v0 on even halves; decryption runs the halves mirrored.
  always_comb begin
    dec    = (blk_i.pay.cmd == CMD_DECRYPT);
    upd_v0 = EVEN ? !dec : dec;
    src    = upd_v0 ? blk_i.pay.v1 : blk_i.pay.v0;
    tgt    = upd_v0 ? blk_i.pay.v0 : blk_i.pay.v1;
    sum    = dec ? DEC_SUM : ENC_SUM;
    key    = dec ? key_i[DEC_KIDX] : key_i[ENC_KIDX];
    f      = mix(src) ^ (sum + key);
    res    = dec ? (tgt - f) : (tgt + f);
  end

  // Place the new word back in its half of the block.
  always_comb begin
    pay_nxt     = blk_i.pay;
    if (upd_v0) begin
      pay_nxt.v0 = res;
    end else begin
      pay_nxt.v1 = res;
    end
  end

  // Valid bit is control state and resets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= blk_i.valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
  end

  assign blk_o.valid = valid_r;
  assign blk_o.pay   = pay_r;

endmodule

@@ rtl/core/xtea_block_cipher_unit.sv @@
// Top level of the pipelined XTEA block cipher with its key registers.
`timescale 1ns / 1ps

// XTEA cipher, one 64-bit block per word. A word is taken at every clock
// edge where start is high and busy is low; busy is high only in reset
// and in the cycle after it, so blocks may follow each other in every
// cycle. Each half-round has its own register stage, 2*ROUNDS stages in
// all, so each result appears on the out_ ports with out_valid, in order,
// for one cycle. The receiver cannot stall. cmd 0 encrypts, 1 decrypts.
// Key words are written at cfg_index 0 to 3 (other indexes are ignored)
// and should be written only while no block is in flight.

module xtea_block_cipher_unit #(
  parameter int ROUNDS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_cmd,
  input  logic [xbc_pkg::WORD_W-1:0]            in_first_word,
  input  logic [xbc_pkg::WORD_W-1:0]            in_second_word,
  output logic                                  out_valid,
  output logic [xbc_pkg::WORD_W-1:0]            out_first_word_out,
  output logic [xbc_pkg::WORD_W-1:0]            out_second_word_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [xbc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [xbc_pkg::WORD_W-1:0]            cfg_data
);
  import xbc_pkg::*;

  localparam int STAGES = 2 * ROUNDS;

  key_t key_r;
  logic busy_r;
  blk_t chain [0:STAGES];

  // Key registers, written through the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index <= LAST_KEY_IDX)) begin
      key_r[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // Busy holds off input only while coming out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Entry of the pipeline.
  assign chain[0].valid   = start && !busy_r;
  assign chain[0].pay.cmd = in_cmd;
  assign chain[0].pay.v0  = in_first_word;
  assign chain[0].pay.v1  = in_second_word;

  // One register stage per half-round.
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    xbc_half_round #(
      .ROUNDS (ROUNDS),
      .STAGE  (j)
    ) u_half_round (
      .clk   (clk),
      .rst_n (rst_n),
      .key_i (key_r),
      .blk_i (chain[j]),
      .blk_o (chain[j+1])
    );
  end

  // Result word straight from the last stage register.
  assign out_valid           = chain[STAGES].valid;
  assign out_first_word_out  = chain[STAGES].pay.v0;
  assign out_second_word_out = chain[STAGES].pay.v1;

endmodule

@@ rtl/core/xbc_checker.sv @@
// Port-level checks on the XTEA cipher pipeline, bound to the top level.
`timescale 1ns / 1ps

module xbc_checker #(
  parameter int ROUNDS = 32
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  localparam int LAT = 2 * ROUNDS;

  // Every accepted word comes out after the fixed pipeline latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted word did not come out after the pipeline latency");

  // Every result was caused by a word accepted one latency earlier.
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted word");

  // Busy clears in the cycle after reset is released and stays low.
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside of reset recovery");

  // No result right after reset: the pipeline was flushed.
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind xtea_block_cipher_unit xbc_checker #(.ROUNDS(ROUNDS)) u_xbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
